[rtl/x86_16bit_instruction_decoder_top_assert.svh]
// assertion macros for the instruction decoder
`ifndef X86_16BIT_INSTRUCTION_DECODER_TOP_ASSERT_SVH
`define X86_16BIT_INSTRUCTION_DECODER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define XD_ASSERT_CLK(label, clk_sig, rst_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) else $error(msg);
`define XD_ASSERT_NEVER(label, clk_sig, rst_sig, cond, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) !(cond)) else $error(msg);
`else
`define XD_ASSERT_CLK(label, clk_sig, rst_sig, prop, msg)
`define XD_ASSERT_NEVER(label, clk_sig, rst_sig, cond, msg)
`endif
`endif

[rtl/x86dec_pkg.sv]
package x86dec_pkg;

    localparam logic [3:0] MAX_LENGTH = 4'd15;

    localparam logic [3:0] K_NONE   = 4'd0;
    localparam logic [3:0] K_R8     = 4'd1;
    localparam logic [3:0] K_R16    = 4'd2;
    localparam logic [3:0] K_SREG   = 4'd3;
    localparam logic [3:0] K_M8     = 4'd4;
    localparam logic [3:0] K_M16    = 4'd5;
    localparam logic [3:0] K_I8     = 4'd6;
    localparam logic [3:0] K_I16    = 4'd7;
    localparam logic [3:0] K_FAR    = 4'd8;
    localparam logic [3:0] K_FARMEM = 4'd9;

    localparam logic [7:0] PFX_REP   = 8'hf3;
    localparam logic [7:0] PFX_REPNE = 8'hf2;
    localparam logic [7:0] PFX_LOCK  = 8'hf0;
    localparam logic [7:0] PFX_CS    = 8'h2e;
    localparam logic [7:0] PFX_DS    = 8'h3e;
    localparam logic [7:0] PFX_ES    = 8'h26;
    localparam logic [7:0] PFX_SS    = 8'h36;

    localparam logic [1:0] REP_NONE = 2'd0;
    localparam logic [1:0] REP_F3   = 2'd1;
    localparam logic [1:0] REP_F2   = 2'd2;

    localparam logic [2:0] SEG_NONE = 3'd0;
    localparam logic [2:0] SEG_CS   = 3'd1;
    localparam logic [2:0] SEG_DS   = 3'd2;
    localparam logic [2:0] SEG_ES   = 3'd3;
    localparam logic [2:0] SEG_SS   = 3'd4;

    // one finished instruction as gathered by the front end
    typedef struct packed {
        logic [1:0]  rep;
        logic        lock;
        logic [2:0]  seg;
        logic [7:0]  opcode;
        logic [7:0]  modrm;
        logic [15:0] disp;
        logic [15:0] imm;
        logic [3:0]  len;
    } raw_insn_t;

    typedef struct packed {
        logic        ok;
        logic [1:0]  rep;
        logic        lock;
        logic [2:0]  seg;
        logic [6:0]  mn;
        logic [3:0]  k1;
        logic [3:0]  s1;
        logic [3:0]  k2;
        logic [3:0]  s2;
        logic [15:0] disp;
        logic [15:0] imm;
        logic [3:0]  len;
    } dec_insn_t;

    function automatic logic has_modrm(input logic [7:0] op);
        logic r;
        r = 1'b0;
        if (op < 8'h40) r = (op[2:0] < 3'd4);
        else if (op >= 8'h80 && op <= 8'h8f) r = 1'b1;
        else if (op >= 8'hc4 && op <= 8'hc7) r = 1'b1;
        else if (op >= 8'hd0 && op <= 8'hd3) r = 1'b1;
        else r = (op == 8'hf6) || (op == 8'hf7) || (op == 8'hfe) || (op == 8'hff);
        return r;
    endfunction

    function automatic logic [1:0] disp_count(input logic [7:0] op, input logic [7:0] m);
        logic [1:0] r;
        r = 2'd0;
        if (has_modrm(op)) begin
            if (m[7:6] == 2'd1) r = 2'd1;
            else if (m[7:6] == 2'd2) r = 2'd2;
            else if (m[7:6] == 2'd0 && m[2:0] == 3'd6) r = 2'd2;
        end
        else if (op == 8'h9a || op == 8'hea || (op >= 8'ha0 && op <= 8'ha3)) begin
            r = 2'd2;
        end
        return r;
    endfunction

    function automatic logic [1:0] imm_count(input logic [7:0] op, input logic [7:0] m);
        logic [1:0] r;
        logic       reg0;
        reg0 = (m[5:3] == 3'd0);
        r = 2'd0;
        if (op < 8'h40) begin
            if (op[2:0] == 3'd4) r = 2'd1;
            else if (op[2:0] == 3'd5) r = 2'd2;
        end
        else if (op >= 8'h70 && op <= 8'h7f) r = 2'd1;
        else if (op >= 8'hb0 && op <= 8'hb7) r = 2'd1;
        else if (op >= 8'hb8 && op <= 8'hbf) r = 2'd2;
        else if (op >= 8'he0 && op <= 8'he7) r = 2'd1;
        else begin
            case (op)
                8'h80, 8'h82, 8'h83, 8'ha8, 8'hcd, 8'hd4, 8'hd5, 8'heb: r = 2'd1;
                8'h81, 8'h9a, 8'hea, 8'ha9, 8'hc2, 8'hca, 8'he8, 8'he9: r = 2'd2;
                8'hc6, 8'hf6: r = reg0 ? 2'd1 : 2'd0;
                8'hc7, 8'hf7: r = reg0 ? 2'd2 : 2'd0;
                default: r = 2'd0;
            endcase
        end
        return r;
    endfunction

    function automatic logic [6:0] alu_code(input logic [2:0] i);
        logic [6:0] r;
        case (i)
            3'd0: r = 7'd0;
            3'd1: r = 7'd3;
            3'd2: r = 7'd4;
            3'd3: r = 7'd5;
            3'd4: r = 7'd6;
            3'd5: r = 7'd8;
            3'd6: r = 7'd10;
            default: r = 7'd12;
        endcase
        return r;
    endfunction

endpackage

[rtl/x86dec_front.sv]
module x86dec_front
    import x86dec_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           byte_valid,
    output logic           byte_ready,
    input  logic [7:0]     code_byte,
    output logic           raw_valid,
    input  logic           raw_ready,
    output raw_insn_t      raw_insn
);

    typedef enum logic [2:0] {
        PH_OPCODE, PH_MODRM, PH_DISP0, PH_DISP1, PH_IMM0, PH_IMM1
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  rep_reg, rep_next;
    logic        lock_reg, lock_next;
    logic [2:0]  seg_reg, seg_next;
    logic [7:0]  op_reg, op_next;
    logic [7:0]  modrm_reg, modrm_next;
    logic [15:0] disp_reg, disp_next;
    logic [15:0] imm_reg, imm_next;
    logic [3:0]  len_reg, len_next;
    logic        done;
    logic [3:0]  len_inc;
    logic [1:0]  dn, imn;
    logic        take;
    logic [7:0]  op_cur, modrm_cur;

    assign byte_ready = raw_ready;
    assign take       = byte_valid && byte_ready;
    assign len_inc    = (len_reg < MAX_LENGTH) ? len_reg + 4'd1 : len_reg;
    assign op_cur     = (phase_reg == PH_OPCODE) ? code_byte : op_reg;
    assign modrm_cur  = (phase_reg == PH_OPCODE) ? 8'd0
                      : ((phase_reg == PH_MODRM) ? code_byte : modrm_reg);
    assign dn         = disp_count(op_cur, modrm_cur);
    assign imn        = imm_count(op_cur, modrm_cur);

    always_comb
    begin
        phase_next = phase_reg;
        rep_next   = rep_reg;
        lock_next  = lock_reg;
        seg_next   = seg_reg;
        op_next    = op_reg;
        modrm_next = modrm_reg;
        disp_next  = disp_reg;
        imm_next   = imm_reg;
        len_next   = len_inc;
        done       = 1'b0;
        unique case (phase_reg)
            PH_OPCODE:
            begin
                case (code_byte)
                    PFX_REP: rep_next = REP_F3;
                    PFX_REPNE: rep_next = REP_F2;
                    PFX_LOCK: lock_next = 1'b1;
                    PFX_CS: seg_next = SEG_CS;
                    PFX_DS: seg_next = SEG_DS;
                    PFX_ES: seg_next = SEG_ES;
                    PFX_SS: seg_next = SEG_SS;
                    default:
                    begin
                        op_next    = code_byte;
                        modrm_next = 8'd0;
                        if (has_modrm(code_byte)) phase_next = PH_MODRM;
                        else if (dn != 2'd0) phase_next = PH_DISP0;
                        else if (imn != 2'd0) phase_next = PH_IMM0;
                        else done = 1'b1;
                    end
                endcase
            end
            PH_MODRM:
            begin
                modrm_next = code_byte;
                if (dn != 2'd0) phase_next = PH_DISP0;
                else if (imn != 2'd0) phase_next = PH_IMM0;
                else done = 1'b1;
            end
            PH_DISP0:
            begin
                disp_next = {8'd0, code_byte};
                if (dn == 2'd2) phase_next = PH_DISP1;
                else
                begin
                    disp_next = {{8{code_byte[7]}}, code_byte};
                    if (imn != 2'd0) phase_next = PH_IMM0;
                    else done = 1'b1;
                end
            end
            PH_DISP1:
            begin
                disp_next = {code_byte, disp_reg[7:0]};
                if (imn != 2'd0) phase_next = PH_IMM0;
                else done = 1'b1;
            end
            PH_IMM0:
            begin
                imm_next = {8'd0, code_byte};
                if (imn == 2'd2) phase_next = PH_IMM1;
                else done = 1'b1;
            end
            PH_IMM1:
            begin
                imm_next = {code_byte, imm_reg[7:0]};
                done = 1'b1;
            end
            default: done = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_OPCODE;
            rep_reg   <= REP_NONE;
            lock_reg  <= 1'b0;
            seg_reg   <= SEG_NONE;
            op_reg    <= 8'd0;
            modrm_reg <= 8'd0;
            disp_reg  <= 16'd0;
            imm_reg   <= 16'd0;
            len_reg   <= 4'd0;
            raw_valid <= 1'b0;
            raw_insn  <= '0;
        end
        else
        begin
            if (take && done) raw_valid <= 1'b1;
            else if (raw_ready) raw_valid <= 1'b0;
            if (take)
            begin
                op_reg    <= op_next;
                modrm_reg <= modrm_next;
                if (done)
                begin
                    raw_insn.rep    <= rep_next;
                    raw_insn.lock   <= lock_next;
                    raw_insn.seg    <= seg_next;
                    raw_insn.opcode <= op_next;
                    raw_insn.modrm  <= modrm_next;
                    raw_insn.disp   <= disp_next;
                    raw_insn.imm    <= imm_next;
                    raw_insn.len    <= len_next;
                    phase_reg <= PH_OPCODE;
                    rep_reg   <= REP_NONE;
                    lock_reg  <= 1'b0;
                    seg_reg   <= SEG_NONE;
                    disp_reg  <= 16'd0;
                    imm_reg   <= 16'd0;
                    len_reg   <= 4'd0;
                end
                else
                begin
                    phase_reg <= phase_next;
                    rep_reg   <= rep_next;
                    lock_reg  <= lock_next;
                    seg_reg   <= seg_next;
                    disp_reg  <= disp_next;
                    imm_reg   <= imm_next;
                    len_reg   <= len_next;
                end
            end
        end
    end

endmodule

[rtl/x86dec_queue.sv]
`include "x86_16bit_instruction_decoder_top_assert.svh"
module x86dec_queue
    import x86dec_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  raw_insn_t in_insn,
    output logic      out_valid,
    input  logic      out_ready,
    output raw_insn_t out_insn
);

    // two-entry queue
    raw_insn_t  q_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_insn  = q_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push) q_reg[wp_reg] <= in_insn;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            if (push && !pop) cnt_reg <= cnt_reg + 2'd1;
            else if (pop && !push) cnt_reg <= cnt_reg - 2'd1;
        end
    end

    `XD_ASSERT_NEVER(a_cnt_range, clk, rst_n, cnt_reg == 2'd3, "queue count out of range")
    `XD_ASSERT_CLK(a_ptr_gap, clk, rst_n, (cnt_reg == 2'd1) |-> (wp_reg != rp_reg), "pointer mismatch")
    `XD_ASSERT_CLK(a_ptr_eq, clk, rst_n, (cnt_reg != 2'd1) |-> (wp_reg == rp_reg), "pointer mismatch")

endmodule

[rtl/x86dec_back.sv]
module x86dec_back
    import x86dec_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  raw_insn_t in_insn,
    output logic      out_valid,
    input  logic      out_ready,
    output dec_insn_t out_insn
);

    logic [7:0]  op, m;
    logic [1:0]  md;
    logic [2:0]  rg;
    logic        w, d;
    logic        ok;
    logic [6:0]  mn;
    logic [3:0]  k1, s1, k2, s2, rk, rs, rk16, gk, ik, mk;
    logic [15:0] imm;
    dec_insn_t   res;

    assign op = in_insn.opcode;
    assign m  = in_insn.modrm;
    assign md = m[7:6];
    assign rg = m[5:3];
    assign w  = op[0];
    assign d  = op[1];
    assign gk = w ? K_R16 : K_R8;
    assign ik = w ? K_I16 : K_I8;
    assign mk = w ? K_M16 : K_M8;
    assign rs = (md == 2'd0 && m[2:0] == 3'd6) ? 4'd8 : ((md == 2'd3) ? {1'b0, m[2:0]}
                                                                    : {1'b0, m[2:0]});
    assign rk   = (md == 2'd3) ? gk : mk;
    assign rk16 = (md == 2'd3) ? K_R16 : K_M16;

    always_comb
    begin
        ok = 1'b1; mn = 7'd0; k1 = K_NONE; s1 = 4'd0; k2 = K_NONE; s2 = 4'd0;
        imm = in_insn.imm;
        if (op < 8'h40)
        begin
            if (op[2:0] < 3'd4)
            begin
                mn = alu_code(op[5:3]);
                if (d) begin k1 = gk; s1 = {1'b0, rg}; k2 = rk; s2 = rs; end
                else begin k1 = rk; s1 = rs; k2 = gk; s2 = {1'b0, rg}; end
            end
            else if (op[2:1] == 2'b10)
            begin
                mn = alu_code(op[5:3]); k1 = gk; k2 = ik;
            end
            else if (op[5:3] < 3'd4 && op != 8'h0f)
            begin
                mn = op[0] ? 7'd2 : 7'd1; k1 = K_SREG; s1 = {1'b0, op[5:3]};
            end
            else if (op[0] && op[5:3] >= 3'd4)
            begin
                mn = 7'd7 + {3'd0, op[4:3], 1'b0};
            end
            else ok = 1'b0;
        end
        else if (op < 8'h60)
        begin
            case (op[4:3])
                2'd0: mn = 7'd14;
                2'd1: mn = 7'd15;
                2'd2: mn = 7'd1;
                default: mn = 7'd2;
            endcase
            k1 = K_R16; s1 = {1'b0, op[2:0]};
        end
        else if (op < 8'h70) ok = 1'b0;
        else if (op < 8'h80)
        begin
            mn = 7'd16 + {3'd0, op[3:0]}; k1 = K_I8;
        end
        else if (op >= 8'hb0 && op <= 8'hbf)
        begin
            mn = 7'd34; k1 = op[3] ? K_R16 : K_R8; s1 = {1'b0, op[2:0]};
            k2 = op[3] ? K_I16 : K_I8;
        end
        else if (op >= 8'ha4 && op <= 8'ha7)
        begin
            mn = 7'd45 + {5'd0, op[1:0]};
        end
        else if (op >= 8'haa && op <= 8'haf)
        begin
            mn = 7'd49 + {4'd0, op[2:0]} - 7'd2;
        end
        else if (op >= 8'hf8 && op <= 8'hfd)
        begin
            mn = 7'd87 + {4'd0, op[2:0]};
        end
        else
        begin
            case (op)
                8'h80, 8'h81, 8'h82, 8'h83:
                begin
                    mn = alu_code(rg); k1 = rk; s1 = rs;
                    k2 = (op == 8'h81) ? K_I16 : K_I8;
                end
                8'h84, 8'h85, 8'h86, 8'h87:
                begin
                    mn = d ? 7'd33 : 7'd32; k1 = gk; s1 = {1'b0, rg}; k2 = rk; s2 = rs;
                end
                8'h88, 8'h89, 8'h8a, 8'h8b:
                begin
                    mn = 7'd34;
                    if (d) begin k1 = gk; s1 = {1'b0, rg}; k2 = rk; s2 = rs; end
                    else begin k1 = rk; s1 = rs; k2 = gk; s2 = {1'b0, rg}; end
                end
                8'h8c, 8'h8e:
                begin
                    if (rg[2]) ok = 1'b0;
                    else
                    begin
                        mn = 7'd34;
                        if (op == 8'h8c) begin k1 = rk16; s1 = rs; k2 = K_SREG; s2 = {1'b0, rg}; end
                        else begin k1 = K_SREG; s1 = {1'b0, rg}; k2 = rk16; s2 = rs; end
                    end
                end
                8'h8d, 8'hc4, 8'hc5:
                begin
                    if (md == 2'd3) ok = 1'b0;
                    else
                    begin
                        mn = (op == 8'h8d) ? 7'd35 : ((op == 8'hc4) ? 7'd56 : 7'd57);
                        k1 = K_R16; s1 = {1'b0, rg}; k2 = rk16; s2 = rs;
                    end
                end
                8'h8f:
                begin
                    if (rg != 3'd0) ok = 1'b0;
                    else begin mn = 7'd2; k1 = rk16; s1 = rs; end
                end
                8'h90: mn = 7'd36;
                8'h91, 8'h92, 8'h93, 8'h94, 8'h95, 8'h96, 8'h97:
                begin
                    mn = 7'd33; k1 = K_R16; s1 = {1'b0, op[2:0]}; k2 = K_R16;
                end
                8'h98: mn = 7'd37;
                8'h99: mn = 7'd38;
                8'h9a: begin mn = 7'd39; k1 = K_FAR; end
                8'h9b: mn = 7'd40;
                8'h9c: mn = 7'd41;
                8'h9d: mn = 7'd42;
                8'h9e: mn = 7'd43;
                8'h9f: mn = 7'd44;
                8'ha0, 8'ha1, 8'ha2, 8'ha3:
                begin
                    mn = 7'd34;
                    if (d) begin k1 = mk; s1 = 4'd8; k2 = gk; end
                    else begin k1 = gk; k2 = mk; s2 = 4'd8; end
                end
                8'ha8, 8'ha9: begin mn = 7'd32; k1 = gk; k2 = ik; end
                8'hc2: begin mn = 7'd55; k1 = K_I16; end
                8'hc3: mn = 7'd55;
                8'hc6, 8'hc7:
                begin
                    if (rg != 3'd0) ok = 1'b0;
                    else begin mn = 7'd34; k1 = rk; s1 = rs; k2 = ik; end
                end
                8'hca: begin mn = 7'd58; k1 = K_I16; end
                8'hcb: mn = 7'd58;
                8'hcc: begin mn = 7'd59; k1 = K_I8; imm = 16'd3; end
                8'hcd: begin mn = 7'd59; k1 = K_I8; end
                8'hce: mn = 7'd60;
                8'hcf: mn = 7'd61;
                8'hd0, 8'hd1, 8'hd2, 8'hd3:
                begin
                    if (rg == 3'd6) ok = 1'b0;
                    else
                    begin
                        mn = (rg == 3'd7) ? 7'd68 : 7'd62 + {4'd0, rg};
                        k1 = rk; s1 = rs;
                        if (!d) begin k2 = K_I8; imm = 16'd1; end
                        else begin k2 = K_R8; s2 = 4'd1; end
                    end
                end
                8'hd4: begin mn = 7'd69; k1 = K_I8; end
                8'hd5: begin mn = 7'd70; k1 = K_I8; end
                8'hd7: mn = 7'd71;
                8'he0, 8'he1, 8'he2, 8'he3: begin mn = 7'd72 + {5'd0, op[1:0]}; k1 = K_I8; end
                8'he4, 8'he5: begin mn = 7'd76; k1 = gk; k2 = K_I16; end
                8'he6, 8'he7: begin mn = 7'd77; k1 = K_I16; k2 = gk; end
                8'he8: begin mn = 7'd39; k1 = K_I16; end
                8'he9: begin mn = 7'd78; k1 = K_I16; end
                8'hea: begin mn = 7'd78; k1 = K_FAR; end
                8'heb: begin mn = 7'd78; k1 = K_I8; end
                8'hec, 8'hed: begin mn = 7'd76; k1 = gk; k2 = K_R16; s2 = 4'd2; end
                8'hee, 8'hef: begin mn = 7'd77; k1 = K_R16; s1 = 4'd2; k2 = gk; end
                8'hf4: mn = 7'd79;
                8'hf5: mn = 7'd80;
                8'hf6, 8'hf7:
                begin
                    if (rg == 3'd1) ok = 1'b0;
                    else
                    begin
                        k1 = rk; s1 = rs;
                        if (rg == 3'd0) begin mn = 7'd32; k2 = ik; end
                        else mn = 7'd79 + {4'd0, rg};
                    end
                end
                8'hfe:
                begin
                    if (rg > 3'd1) ok = 1'b0;
                    else begin mn = 7'd14 + {6'd0, rg[0]}; k1 = rk; s1 = rs; end
                end
                8'hff:
                begin
                    if (rg == 3'd7) ok = 1'b0;
                    else if ((rg == 3'd3 || rg == 3'd5) && md == 2'd3) ok = 1'b0;
                    else
                    begin
                        k1 = (rg == 3'd3 || rg == 3'd5) ? K_FARMEM : rk16;
                        s1 = rs;
                        if (rg < 3'd2) mn = 7'd14 + {6'd0, rg[0]};
                        else if (rg < 3'd4) mn = 7'd39;
                        else if (rg < 3'd6) mn = 7'd78;
                        else mn = 7'd1;
                    end
                end
                default: ok = 1'b0;
            endcase
        end
        res.ok   = ok;
        res.rep  = in_insn.rep;
        res.lock = in_insn.lock;
        res.seg  = in_insn.seg;
        res.len  = in_insn.len;
        res.mn   = ok ? mn : 7'd0;
        res.k1   = ok ? k1 : K_NONE;
        res.s1   = ok ? s1 : 4'd0;
        res.k2   = ok ? k2 : K_NONE;
        res.s2   = ok ? s2 : 4'd0;
        res.disp = ok ? in_insn.disp : 16'd0;
        res.imm  = ok ? imm : 16'd0;
    end

    assign in_ready = !out_valid || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) out_valid <= 1'b0;
        else if (in_ready) out_valid <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid) out_insn <= res;
    end

endmodule

[rtl/x86_16bit_instruction_decoder_top.sv]
// channel   dir  tdata fields (low bit up)
// s_axis    in   code_byte[7:0]
// m_axis    out  decode_ok, repeat_prefix, lock_prefix, segment_override, mnemonic_code,
//                first_kind, first_select, second_kind, second_select, displacement,
//                immediate_value, byte_length (66 bits, zero padded to 72)
// one code byte per cycle is taken while the queue can accept; m_axis_tvalid rises once the
// last byte of a request has passed the front output register, the queue and the back decode register
// front output register, two-entry queue and back decode register each hold one stage
// rst_n clears phase, prefixes and all valid flags
// a stalled m_axis fills the queue, then stalls s_axis
module x86_16bit_instruction_decoder_top
    import x86dec_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // code_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata    // fields as listed above
);

    logic      f_valid, f_ready, q_valid, q_ready;
    raw_insn_t f_insn, q_insn;
    dec_insn_t d_insn;

    x86dec_front u_front (
        .clk(clk), .rst_n(rst_n),
        .byte_valid(s_axis_tvalid), .byte_ready(s_axis_tready), .code_byte(s_axis_tdata),
        .raw_valid(f_valid), .raw_ready(f_ready), .raw_insn(f_insn)
    );

    x86dec_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .in_valid(f_valid), .in_ready(f_ready), .in_insn(f_insn),
        .out_valid(q_valid), .out_ready(q_ready), .out_insn(q_insn)
    );

    x86dec_back u_back (
        .clk(clk), .rst_n(rst_n),
        .in_valid(q_valid), .in_ready(q_ready), .in_insn(q_insn),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_insn(d_insn)
    );

    assign m_axis_tdata = {6'd0, d_insn.len, d_insn.imm, d_insn.disp, d_insn.s2, d_insn.k2,
                           d_insn.s1, d_insn.k1, d_insn.mn, d_insn.seg, d_insn.lock,
                           d_insn.rep, d_insn.ok};

endmodule

[bench/tb_x86_16bit_instruction_decoder_top.sv]
`timescale 1ns / 100ps

module tb_x86_16bit_instruction_decoder_top
    import x86dec_pkg::*;
();

    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;

    localparam logic [6:0] MN_ADD = 7'd0, MN_PUSH = 7'd1, MN_POP = 7'd2, MN_OR = 7'd3,
        MN_ADC = 7'd4, MN_SBB = 7'd5, MN_AND = 7'd6, MN_DAA = 7'd7, MN_SUB = 7'd8,
        MN_XOR = 7'd10, MN_CMP = 7'd12, MN_INC = 7'd14, MN_DEC = 7'd15, MN_JO = 7'd16,
        MN_TEST = 7'd32, MN_XCHG = 7'd33, MN_MOV = 7'd34, MN_LEA = 7'd35, MN_NOP = 7'd36,
        MN_CBW = 7'd37, MN_CALL = 7'd39, MN_MOVSB = 7'd45, MN_STOSB = 7'd49,
        MN_RET = 7'd55, MN_LES = 7'd56, MN_LDS = 7'd57, MN_RETF = 7'd58, MN_INT = 7'd59,
        MN_INTO = 7'd60, MN_IRET = 7'd61, MN_ROL = 7'd62, MN_SAR = 7'd68, MN_AAM = 7'd69,
        MN_AAD = 7'd70, MN_XLAT = 7'd71, MN_LOOPNZ = 7'd72, MN_IN = 7'd76, MN_OUT = 7'd77,
        MN_JMP = 7'd78, MN_HLT = 7'd79, MN_CMC = 7'd80, MN_NOT = 7'd81, MN_CLC = 7'd87;

    typedef enum logic [2:0] {PH_OP, PH_MODRM, PH_D0, PH_D1, PH_I0, PH_I1} phase_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;

    x86_16bit_instruction_decoder_top i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // decoder state mirror
    phase_t      dec_phase;
    logic [1:0]  dec_rep;
    logic        dec_lock;
    logic [2:0]  dec_seg;
    logic [7:0]  dec_op;
    logic [7:0]  dec_modrm;
    logic [15:0] dec_disp;
    logic [15:0] dec_imm;
    logic [3:0]  dec_len;

    dec_insn_t   pending_insns[$];
    int          error_count = 0;
    int          bytes_sent = 0;
    int          insns_checked = 0;
    int          idle_cycles = 0;
    bit          insn_done;
    int          hold_asks = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    bit          choppy = 0;
    int          mode_left = 0;
    int          burst_left = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic bit takes_modrm(input logic [7:0] op);
        if (op < 8'h40) return op[2:0] < 3'd4;
        if (op >= 8'h80 && op <= 8'h8f) return 1;
        if (op >= 8'hc4 && op <= 8'hc7) return 1;
        if (op >= 8'hd0 && op <= 8'hd3) return 1;
        return op == 8'hf6 || op == 8'hf7 || op == 8'hfe || op == 8'hff;
    endfunction

    function automatic int disp_bytes(input logic [7:0] op, input logic [7:0] m);
        if (takes_modrm(op))
        begin
            if (m[7:6] == 2'd1) return 1;
            if (m[7:6] == 2'd2) return 2;
            return (m[7:6] == 2'd0 && m[2:0] == 3'd6) ? 2 : 0;
        end
        if (op == 8'h9a || op == 8'hea || (op >= 8'ha0 && op <= 8'ha3)) return 2;
        return 0;
    endfunction

    function automatic int imm_bytes(input logic [7:0] op, input logic [7:0] m);
        if (op < 8'h40) return op[2:0] == 3'd4 ? 1 : (op[2:0] == 3'd5 ? 2 : 0);
        if ((op >= 8'h70 && op <= 8'h7f) || (op >= 8'hb0 && op <= 8'hb7)
            || (op >= 8'he0 && op <= 8'he7)) return 1;
        if (op >= 8'hb8 && op <= 8'hbf) return 2;
        case (op)
            8'h80, 8'h82, 8'h83, 8'ha8, 8'hcd, 8'hd4, 8'hd5, 8'heb: return 1;
            8'h81, 8'h9a, 8'hea, 8'ha9, 8'hc2, 8'hca, 8'he8, 8'he9: return 2;
            8'hc6, 8'hf6: return m[5:3] == 3'd0 ? 1 : 0;
            8'hc7, 8'hf7: return m[5:3] == 3'd0 ? 2 : 0;
            default: return 0;
        endcase
    endfunction

    function automatic void rm_form(input logic [7:0] m, input bit w,
                                    output logic [3:0] k, output logic [3:0] s);
        if (m[7:6] == 2'd3)
        begin
            k = w ? K_R16 : K_R8;
            s = {1'b0, m[2:0]};
        end
        else
        begin
            k = w ? K_M16 : K_M8;
            s = (m[7:6] == 2'd0 && m[2:0] == 3'd6) ? 4'd8 : {1'b0, m[2:0]};
        end
    endfunction

    function automatic logic [6:0] alu_mn(input logic [2:0] i);
        logic [6:0] t[8];
        t = '{MN_ADD, MN_OR, MN_ADC, MN_SBB, MN_AND, MN_SUB, MN_XOR, MN_CMP};
        return t[i];
    endfunction

    function automatic dec_insn_t finish_insn();
        dec_insn_t r;
        logic [7:0] op;
        logic [2:0] reg_f;
        logic [3:0] reg_s;
        bit w, d;
        logic [3:0] rk, rs, gk, ik;
        op = dec_op;
        reg_f = dec_modrm[5:3];
        reg_s = {1'b0, reg_f};
        w = op[0];
        d = op[1];
        gk = w ? K_R16 : K_R8;
        ik = w ? K_I16 : K_I8;
        r = '0;
        r.ok = 1'b1;
        r.disp = dec_disp;
        r.imm = dec_imm;
        rm_form(dec_modrm, w, rk, rs);
        if (op < 8'h40)
        begin
            if (op[2:0] < 3'd4)
            begin
                r.mn = alu_mn(op[5:3]);
                if (d) begin r.k1 = gk; r.s1 = reg_s; r.k2 = rk; r.s2 = rs; end
                else begin r.k1 = rk; r.s1 = rs; r.k2 = gk; r.s2 = reg_s; end
            end
            else if (op[2:0] < 3'd6)
            begin
                r.mn = alu_mn(op[5:3]); r.k1 = gk; r.k2 = ik;
            end
            else if (op[5:3] < 3'd4 && op != 8'h0f)
            begin
                r.mn = op[0] ? MN_POP : MN_PUSH; r.k1 = K_SREG; r.s1 = {1'b0, op[5:3]};
            end
            else if (op[2:0] == 3'd7 && op[5:3] >= 3'd4)
                r.mn = MN_DAA + 7'(2 * (op[5:3] - 4));
            else
                r.ok = 1'b0;
        end
        else if (op < 8'h60)
        begin
            case (op[4:3])
                2'd0: r.mn = MN_INC;
                2'd1: r.mn = MN_DEC;
                2'd2: r.mn = MN_PUSH;
                default: r.mn = MN_POP;
            endcase
            r.k1 = K_R16; r.s1 = {1'b0, op[2:0]};
        end
        else if (op < 8'h70)
            r.ok = 1'b0;
        else if (op < 8'h80)
        begin
            r.mn = MN_JO + 7'(op[3:0]); r.k1 = K_I8;
        end
        else if (op >= 8'hb0 && op <= 8'hbf)
        begin
            r.mn = MN_MOV; r.k1 = op[3] ? K_R16 : K_R8; r.s1 = {1'b0, op[2:0]};
            r.k2 = op[3] ? K_I16 : K_I8;
        end
        else if (op >= 8'ha4 && op <= 8'ha7)
            r.mn = MN_MOVSB + 7'(op - 8'ha4);
        else if (op >= 8'haa && op <= 8'haf)
            r.mn = MN_STOSB + 7'(op - 8'haa);
        else if (op >= 8'hf8 && op <= 8'hfd)
            r.mn = MN_CLC + 7'(op - 8'hf8);
        else
        begin
            case (op)
                8'h80, 8'h81, 8'h82, 8'h83:
                begin
                    r.mn = alu_mn(reg_f); r.k1 = rk; r.s1 = rs;
                    r.k2 = op == 8'h81 ? K_I16 : K_I8;
                end
                8'h84, 8'h85, 8'h86, 8'h87:
                begin
                    r.mn = op < 8'h86 ? MN_TEST : MN_XCHG;
                    r.k1 = gk; r.s1 = reg_s; r.k2 = rk; r.s2 = rs;
                end
                8'h88, 8'h89, 8'h8a, 8'h8b:
                begin
                    r.mn = MN_MOV;
                    if (d) begin r.k1 = gk; r.s1 = reg_s; r.k2 = rk; r.s2 = rs; end
                    else begin r.k1 = rk; r.s1 = rs; r.k2 = gk; r.s2 = reg_s; end
                end
                8'h8c, 8'h8e:
                begin
                    rm_form(dec_modrm, 1, rk, rs);
                    if (reg_f > 3'd3) r.ok = 1'b0;
                    else
                    begin
                        r.mn = MN_MOV;
                        if (op == 8'h8c)
                        begin r.k1 = rk; r.s1 = rs; r.k2 = K_SREG; r.s2 = reg_s; end
                        else
                        begin r.k1 = K_SREG; r.s1 = reg_s; r.k2 = rk; r.s2 = rs; end
                    end
                end
                8'h8d, 8'hc4, 8'hc5:
                begin
                    rm_form(dec_modrm, 1, rk, rs);
                    if (dec_modrm[7:6] == 2'd3) r.ok = 1'b0;
                    else
                    begin
                        r.mn = op == 8'h8d ? MN_LEA : (op == 8'hc4 ? MN_LES : MN_LDS);
                        r.k1 = K_R16; r.s1 = reg_s; r.k2 = rk; r.s2 = rs;
                    end
                end
                8'h8f:
                begin
                    rm_form(dec_modrm, 1, rk, rs);
                    if (reg_f != 3'd0) r.ok = 1'b0;
                    else begin r.mn = MN_POP; r.k1 = rk; r.s1 = rs; end
                end
                8'h90: r.mn = MN_NOP;
                8'h91, 8'h92, 8'h93, 8'h94, 8'h95, 8'h96, 8'h97:
                begin
                    r.mn = MN_XCHG; r.k1 = K_R16; r.s1 = {1'b0, op[2:0]}; r.k2 = K_R16;
                end
                8'h98, 8'h99, 8'h9b, 8'h9c, 8'h9d, 8'h9e, 8'h9f:
                    r.mn = MN_CBW + 7'(op - 8'h98);
                8'h9a: begin r.mn = MN_CALL; r.k1 = K_FAR; end
                8'ha0, 8'ha1, 8'ha2, 8'ha3:
                begin
                    r.mn = MN_MOV;
                    if (d) begin r.k1 = w ? K_M16 : K_M8; r.s1 = 4'd8; r.k2 = gk; end
                    else begin r.k1 = gk; r.k2 = w ? K_M16 : K_M8; r.s2 = 4'd8; end
                end
                8'ha8, 8'ha9: begin r.mn = MN_TEST; r.k1 = gk; r.k2 = ik; end
                8'hc2: begin r.mn = MN_RET; r.k1 = K_I16; end
                8'hc3: r.mn = MN_RET;
                8'hc6, 8'hc7:
                begin
                    if (reg_f != 3'd0) r.ok = 1'b0;
                    else begin r.mn = MN_MOV; r.k1 = rk; r.s1 = rs; r.k2 = ik; end
                end
                8'hca: begin r.mn = MN_RETF; r.k1 = K_I16; end
                8'hcb: r.mn = MN_RETF;
                8'hcc: begin r.mn = MN_INT; r.k1 = K_I8; r.imm = 16'd3; end
                8'hcd: begin r.mn = MN_INT; r.k1 = K_I8; end
                8'hce: r.mn = MN_INTO;
                8'hcf: r.mn = MN_IRET;
                8'hd0, 8'hd1, 8'hd2, 8'hd3:
                begin
                    if (reg_f == 3'd6) r.ok = 1'b0;
                    else
                    begin
                        r.mn = reg_f == 3'd7 ? MN_SAR : MN_ROL + 7'(reg_f);
                        r.k1 = rk; r.s1 = rs;
                        if (op < 8'hd2) begin r.k2 = K_I8; r.imm = 16'd1; end
                        else begin r.k2 = K_R8; r.s2 = 4'd1; end
                    end
                end
                8'hd4: begin r.mn = MN_AAM; r.k1 = K_I8; end
                8'hd5: begin r.mn = MN_AAD; r.k1 = K_I8; end
                8'hd7: r.mn = MN_XLAT;
                8'he0, 8'he1, 8'he2, 8'he3:
                begin r.mn = MN_LOOPNZ + 7'(op[1:0]); r.k1 = K_I8; end
                8'he4, 8'he5: begin r.mn = MN_IN; r.k1 = gk; r.k2 = K_I16; end
                8'he6, 8'he7: begin r.mn = MN_OUT; r.k1 = K_I16; r.k2 = gk; end
                8'he8: begin r.mn = MN_CALL; r.k1 = K_I16; end
                8'he9: begin r.mn = MN_JMP; r.k1 = K_I16; end
                8'hea: begin r.mn = MN_JMP; r.k1 = K_FAR; end
                8'heb: begin r.mn = MN_JMP; r.k1 = K_I8; end
                8'hec, 8'hed:
                begin r.mn = MN_IN; r.k1 = gk; r.k2 = K_R16; r.s2 = 4'd2; end
                8'hee, 8'hef:
                begin r.mn = MN_OUT; r.k1 = K_R16; r.s1 = 4'd2; r.k2 = gk; end
                8'hf4: r.mn = MN_HLT;
                8'hf5: r.mn = MN_CMC;
                8'hf6, 8'hf7:
                begin
                    if (reg_f == 3'd1) r.ok = 1'b0;
                    else
                    begin
                        r.k1 = rk; r.s1 = rs;
                        if (reg_f == 3'd0) begin r.mn = MN_TEST; r.k2 = ik; end
                        else r.mn = MN_NOT + 7'(reg_f - 2);
                    end
                end
                8'hfe:
                begin
                    if (reg_f > 3'd1) r.ok = 1'b0;
                    else begin r.mn = MN_INC + 7'(reg_f); r.k1 = rk; r.s1 = rs; end
                end
                8'hff:
                begin
                    rm_form(dec_modrm, 1, rk, rs);
                    r.k1 = rk; r.s1 = rs;
                    if (reg_f == 3'd7) r.ok = 1'b0;
                    else if ((reg_f == 3'd3 || reg_f == 3'd5) && dec_modrm[7:6] == 2'd3)
                        r.ok = 1'b0;
                    else
                    begin
                        if (reg_f == 3'd3 || reg_f == 3'd5) r.k1 = K_FARMEM;
                        r.mn = reg_f < 3'd2 ? MN_INC + 7'(reg_f) :
                               (reg_f < 3'd4 ? MN_CALL : (reg_f < 3'd6 ? MN_JMP : MN_PUSH));
                    end
                end
                default: r.ok = 1'b0;
            endcase
        end
        if (!r.ok) r = '0;
        r.rep = dec_rep;
        r.lock = dec_lock;
        r.seg = dec_seg;
        r.len = dec_len;
        dec_phase = PH_OP;
        dec_rep = REP_NONE;
        dec_lock = 1'b0;
        dec_seg = SEG_NONE;
        dec_disp = '0;
        dec_imm = '0;
        dec_len = '0;
        return r;
    endfunction

    // returns 1 when the byte completes an instruction
    function automatic bit decode_byte(input logic [7:0] b, output dec_insn_t r);
        phase_t ph;
        int dn, imn;
        ph = dec_phase;
        if (dec_len < MAX_LENGTH) dec_len++;
        if (ph == PH_OP)
        begin
            case (b)
                PFX_REP: begin dec_rep = REP_F3; return 0; end
                PFX_REPNE: begin dec_rep = REP_F2; return 0; end
                PFX_LOCK: begin dec_lock = 1'b1; return 0; end
                PFX_CS: begin dec_seg = SEG_CS; return 0; end
                PFX_DS: begin dec_seg = SEG_DS; return 0; end
                PFX_ES: begin dec_seg = SEG_ES; return 0; end
                PFX_SS: begin dec_seg = SEG_SS; return 0; end
                default: ;
            endcase
            dec_op = b;
            dec_modrm = '0;
            if (takes_modrm(b)) begin dec_phase = PH_MODRM; return 0; end
        end
        else if (ph == PH_MODRM) dec_modrm = b;
        else if (ph == PH_D0) dec_disp = {8'h00, b};
        else if (ph == PH_D1) dec_disp[15:8] = b;
        else if (ph == PH_I0) dec_imm = {8'h00, b};
        else dec_imm[15:8] = b;
        dn = disp_bytes(dec_op, dec_modrm);
        imn = imm_bytes(dec_op, dec_modrm);
        if (ph <= PH_MODRM)
        begin
            if (dn != 0) begin dec_phase = PH_D0; return 0; end
        end
        else if (ph == PH_D0)
        begin
            if (dn == 2) begin dec_phase = PH_D1; return 0; end
            if (dec_disp[7]) dec_disp[15:8] = 8'hff;
        end
        else if (ph == PH_I0)
        begin
            if (imn == 2) begin dec_phase = PH_I1; return 0; end
            r = finish_insn();
            return 1;
        end
        else if (ph == PH_I1)
        begin
            r = finish_insn();
            return 1;
        end
        if (imn != 0) begin dec_phase = PH_I0; return 0; end
        r = finish_insn();
        return 1;
    endfunction

    task automatic report_mismatch(input string field, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, field, got, want);
        error_count++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        dec_insn_t r;
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
        burst_left--;
        repeat (gap)
        begin
            @(posedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(posedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        @(negedge clk);
        while (!s_axis_tready) @(negedge clk);
        bytes_sent++;
        insn_done = decode_byte(b, r);
        if (insn_done) pending_insns.push_back(r);
    endtask

    task automatic send_insn(input logic [7:0] op, input int prefixes);
        logic [7:0] pfx[7];
        pfx = '{PFX_REP, PFX_REPNE, PFX_LOCK, PFX_CS, PFX_DS, PFX_ES, PFX_SS};
        repeat (prefixes) send_byte(pfx[$urandom_range(0, 6)]);
        insn_done = 0;
        send_byte(op);
        while (!insn_done) send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic wait_drained();
        @(posedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_insns.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic send_list(input logic [7:0] seq[]);
        foreach (seq[i]) send_byte(seq[i]);
    endtask

    task automatic test_directed();
        send_list('{8'h90});
        send_list('{PFX_REP, PFX_REPNE, PFX_LOCK, PFX_CS, PFX_DS, PFX_ES, PFX_SS, 8'ha5});
        send_list('{8'h8d, 8'hc0});
        send_list('{8'h81, 8'h86, 8'h34, 8'h12, 8'hff, 8'hff});
        send_list('{8'h83, 8'h40, 8'h80, 8'h00});
        send_list('{8'h0f, 8'hcc, 8'hfe, 8'hd8});
        send_list('{8'hd2, 8'he0, 8'he4, 8'h7f});
        send_list('{8'h9a, 8'h01, 8'h02, 8'h03, 8'h04});
        // prefix run up to the length limit
        repeat (14) send_byte(PFX_LOCK);
        send_byte(8'h90);
        wait_drained();
    endtask

    task automatic test_opcode_sweep();
        int order[256];
        foreach (order[i]) order[i] = i;
        order.shuffle();
        foreach (order[i])
            send_insn(order[i][7:0], ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : 0);
        wait_drained();
    endtask

    task automatic test_random_stream();
        int start;
        start = bytes_sent;
        while (bytes_sent - start < 60)
        begin
            if ($urandom_range(0, 9) == 0) send_byte(8'($urandom_range(0, 255)));
            else send_insn(8'($urandom_range(0, 255)), $urandom_range(0, 2));
        end
        wait_drained();
    endtask

    task automatic test_output_hold();
        hold_asks++;
        repeat (12) send_insn(8'($urandom_range(0, 255)), 0);
        wait_drained();
    endtask

    always @(posedge clk)
    begin
        if (hold_seen != hold_asks)
        begin
            hold_seen <= hold_asks;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                choppy <= ($urandom_range(0, 1) == 1);
                mode_left <= $urandom_range(20, 80);
            end
            else
                mode_left <= mode_left - 1;
            m_axis_tready <= choppy ? ($urandom_range(0, 2) != 0) : 1'b1;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_insns.size() == 0)
                report_mismatch("unexpected result", 16'd1, 16'd0);
            else
            begin
                dec_insn_t w;
                w = pending_insns.pop_front();
                insns_checked++;
                if (m_axis_tdata[0] !== w.ok)
                    report_mismatch("decode_ok", 16'(m_axis_tdata[0]), 16'(w.ok));
                if (m_axis_tdata[2:1] !== w.rep)
                    report_mismatch("repeat_prefix", 16'(m_axis_tdata[2:1]), 16'(w.rep));
                if (m_axis_tdata[3] !== w.lock)
                    report_mismatch("lock_prefix", 16'(m_axis_tdata[3]), 16'(w.lock));
                if (m_axis_tdata[6:4] !== w.seg)
                    report_mismatch("segment_override", 16'(m_axis_tdata[6:4]), 16'(w.seg));
                if (m_axis_tdata[13:7] !== w.mn)
                    report_mismatch("mnemonic_code", 16'(m_axis_tdata[13:7]), 16'(w.mn));
                if (m_axis_tdata[17:14] !== w.k1)
                    report_mismatch("first_kind", 16'(m_axis_tdata[17:14]), 16'(w.k1));
                if (m_axis_tdata[21:18] !== w.s1)
                    report_mismatch("first_select", 16'(m_axis_tdata[21:18]), 16'(w.s1));
                if (m_axis_tdata[25:22] !== w.k2)
                    report_mismatch("second_kind", 16'(m_axis_tdata[25:22]), 16'(w.k2));
                if (m_axis_tdata[29:26] !== w.s2)
                    report_mismatch("second_select", 16'(m_axis_tdata[29:26]), 16'(w.s2));
                if (m_axis_tdata[45:30] !== w.disp)
                    report_mismatch("displacement", m_axis_tdata[45:30], w.disp);
                if (m_axis_tdata[61:46] !== w.imm)
                    report_mismatch("immediate_value", m_axis_tdata[61:46], w.imm);
                if (m_axis_tdata[65:62] !== w.len)
                    report_mismatch("byte_length", 16'(m_axis_tdata[65:62]), 16'(w.len));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout waiting for a handshake");
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        dec_phase = PH_OP;
        dec_rep = REP_NONE;
        dec_lock = 1'b0;
        dec_seg = SEG_NONE;
        dec_op = '0;
        dec_modrm = '0;
        dec_disp = '0;
        dec_imm = '0;
        dec_len = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_opcode_sweep();
        test_output_hold();
        test_random_stream();
        $display("sent %0d code bytes, checked %0d decoded instructions", bytes_sent,
                 insns_checked);
        $display("all 256 opcodes with random prefixes, operands and output stalls");
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/x86dec_pkg.sv
rtl/x86dec_front.sv
rtl/x86dec_queue.sv
rtl/x86dec_back.sv
rtl/x86_16bit_instruction_decoder_top.sv
bench/tb_x86_16bit_instruction_decoder_top.sv
